// ----- hdl/stcp_pkg.sv -----
// Shared constants, types and helper functions for the scope trace capture block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stcp_pkg;

	// Screen geometry
	localparam int COLUMNS      = 120;
	localparam int IDX_W        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int CNT_W        = $clog2(COLUMNS + 1);
	localparam int GRID_SPACING = 30;
	localparam int ROW_TOP      = 13;
	localparam int ROW_MID      = 38;
	localparam int ROW_BOTTOM   = 63;

	// Field widths
	localparam int COL_OUT_W  = 7;
	localparam int ROW_W      = 8;
	localparam int SAMPLE_W   = 8;
	localparam int STEP_W     = 4;
	localparam int GAIN_W     = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Row arithmetic: row = (64.0 in Q8 - (sample/5)*gain) / 256
	localparam int QUOT_W     = 6;
	localparam int PROD_W     = QUOT_W + GAIN_W;
	localparam int ORIGIN_Q8  = 16384;
	localparam int DIV5_MUL   = 205;
	localparam int DIV5_SHIFT = 10;

	// Trigger window test: |sample*50 - step*1275| < 255
	localparam int TRIG_SAMPLE_SCALE = 50;
	localparam int TRIG_STEP_SCALE   = 1275;
	localparam int TRIG_WINDOW       = 255;

	// Result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Register reset values
	localparam logic              SINGLE_MODE_RST  = 1'b0;
	localparam logic [STEP_W-1:0] TRIGGER_STEP_RST = 4'd5;
	localparam logic [GAIN_W-1:0] GAIN_RST         = 10'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SINGLE_MODE  = 2'd0,
		CFG_TRIGGER_STEP = 2'd1,
		CFG_GAIN         = 2'd2
	} cfg_index_t;

	// One pixel operation
	typedef struct packed {
		logic [COL_OUT_W-1:0] column;
		logic [ROW_W-1:0]     row;
		logic                 pixel_on;
		logic                 last;
	} pix_t;

	// Up to two pixel operations pushed by one sample
	typedef struct packed {
		logic first_en;
		logic second_en;
		pix_t first;
		pix_t second;
	} pix_pair_t;

	// Exact sample/5 for eight-bit values by reciprocal multiply
	function automatic logic [QUOT_W-1:0] div5(input logic [SAMPLE_W-1:0] s);
		logic [17:0] p;
		p = 18'(s) * 18'(DIV5_MUL);
		return QUOT_W'(p >> DIV5_SHIFT);
	endfunction

	// Column on a vertical grid line (multiple of the grid spacing)
	function automatic logic is_grid_col(input logic [COL_OUT_W-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k <= (COLUMNS - 1) / GRID_SPACING; k++) begin
			if ({1'b0, c} == 8'(k * GRID_SPACING))
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ----- hdl/stcp_front.sv -----
// Row and trigger arithmetic for one sample: gain multiply, rounding toward zero,
// draw test and trigger window test. Depends on stcp_pkg.
`timescale 1ns / 1ps

module stcp_front
	import stcp_pkg::*;
(
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [QUOT_W-1:0]   quot,
	input  logic [GAIN_W-1:0]   gain_q8,
	input  logic [STEP_W-1:0]   trigger_step,
	output logic [ROW_W-1:0]    row,
	output logic                draw,
	output logic                hit
);

	localparam int DIFF_W = PROD_W + 2;
	localparam int ROWF_W = DIFF_W - 8;

	logic [PROD_W-1:0]        prod;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] biased;
	logic signed [ROWF_W-1:0] row_full;
	logic [13:0]              s_term;
	logic [14:0]              t_term;
	logic signed [15:0]       tdiff;

	// Screen row, divided by 256 with truncation toward zero
	always_comb begin
		prod     = PROD_W'(quot) * PROD_W'(gain_q8);
		diff     = $signed(DIFF_W'(ORIGIN_Q8)) - $signed({2'b00, prod});
		biased   = diff[DIFF_W-1] ? diff + $signed(DIFF_W'(255)) : diff;
		row_full = biased[DIFF_W-1:8];
		row      = row_full[ROW_W-1:0];
		draw     = row_full > $signed(ROWF_W'(ROW_TOP));
	end

	// Trigger window, strict on both sides
	always_comb begin
		s_term = 14'(sample) * 14'(TRIG_SAMPLE_SCALE);
		t_term = 15'(trigger_step) * 15'(TRIG_STEP_SCALE);
		tdiff  = $signed({2'b00, s_term}) - $signed({1'b0, t_term});
		hit    = (tdiff > $signed(16'(-TRIG_WINDOW))) && (tdiff < $signed(16'(TRIG_WINDOW)));
	end

endmodule

// ----- hdl/stcp_fifo.sv -----
// Small result queue of pixel operations: takes up to two per cycle, gives one.
// Depends on stcp_pkg.
`timescale 1ns / 1ps

module stcp_fifo
	import stcp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pix_pair_t push,
	input  logic      pop,
	output pix_t      head,
	output logic      not_empty,
	output logic      room2
);

	pix_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic [QPTR_W:0]   n_push;
	logic [QPTR_W-1:0] wr_next;

	assign n_push    = (QPTR_W + 1)'(push.first_en) + (QPTR_W + 1)'(push.second_en);
	assign wr_next   = QPTR_W'(wr_ptr_q + 1'b1);
	assign head      = ent_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign room2     = count_q <= (QPTR_W + 1)'(QUEUE_DEPTH - 2);

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.first_en)
			ent_q[wr_ptr_q] <= push.first;
		if (push.second_en)
			ent_q[wr_next] <= push.second;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= QPTR_W'(wr_ptr_q + n_push[QPTR_W-1:0]);
			if (pop)
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			count_q <= count_q + n_push - (QPTR_W + 1)'(pop);
		end
	end

endmodule

// ----- hdl/scope_trigger_capture_plot.sv -----
// Top level of the scope trace capture and plot block: config registers, sample
// pipeline, line store and trigger state. Depends on stcp_pkg, stcp_front, stcp_fifo.
`timescale 1ns / 1ps

// Takes one eight-bit sample per transfer and emits zero, one or two pixel
// operations (an erase of the column's old point, then a draw of the new one).
// A sample enters the record stage only after the one before it is committed:
// the line store is read as it enters, and the column is committed, once the
// queue has room for two, before the next sample reads it. Results leave at one
// per cycle while out_ready is high; a four-entry queue lets inputs go on meanwhile.
// The line store needs no clearing pass after reset: each column has a valid
// flag, and an unwritten column reads as row zero.
module scope_trigger_capture_plot
	import stcp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COL_OUT_W-1:0]  column,
	output logic [ROW_W-1:0]      row,
	output logic                  pixel_on,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration
	logic              single_mode_q;
	logic [STEP_W-1:0] trigger_step_q;
	logic [GAIN_W-1:0] gain_q8_q;

	// Trace state
	logic [CNT_W-1:0]   wcol_q;
	logic               filled_q;
	logic               armed_q;
	logic [ROW_W-1:0]   ls0_q;
	logic [ROW_W-1:0]   ls1_q;
	logic [COLUMNS-1:0] colv_q;
	logic [ROW_W-1:0]   line_mem [COLUMNS];

	// Input stage
	logic                s1_valid_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [QUOT_W-1:0]   quot_s1;

	// Record stage
	logic             s2_valid_q;
	logic [ROW_W-1:0] row_s2;
	logic             draw_s2;
	logic             hit_s2;
	logic [IDX_W-1:0] col_s2;
	logic             wrap_s2;
	logic             idle_s2;
	logic [ROW_W-1:0] old_s2;
	logic             oldv_s2;

	logic             unarmed;
	logic             wrap_now;
	logic [IDX_W-1:0] rd_col;
	logic [ROW_W-1:0] f_row;
	logic             f_draw;
	logic             f_hit;
	logic             move;
	logic             commit;
	logic             record;
	logic             filled_n;
	logic [ROW_W-1:0] old_row;
	logic             erase;
	logic             stop;
	logic             draw;
	pix_t             draw_op;
	pix_t             erase_op;
	pix_pair_t        push;
	pix_t             head;
	logic             room2;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_mode_q  <= SINGLE_MODE_RST;
			trigger_step_q <= TRIGGER_STEP_RST;
			gain_q8_q      <= GAIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SINGLE_MODE:  single_mode_q  <= cfg_data[0];
				CFG_TRIGGER_STEP: trigger_step_q <= cfg_data[STEP_W-1:0];
				CFG_GAIN:         gain_q8_q      <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow: a sample enters the record stage only when it is empty
	assign move     = s1_valid_q && !s2_valid_q;
	assign commit   = s2_valid_q && room2;
	assign in_ready = !s1_valid_q || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				s1_valid_q <= in_valid;
			if (move)
				s2_valid_q <= 1'b1;
			else if (commit)
				s2_valid_q <= 1'b0;
		end
	end

	// Input register, quotient by five taken on the way in
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
			quot_s1   <= div5(sample);
		end
	end

	stcp_front u_front (
		.sample       (sample_s1),
		.quot         (quot_s1),
		.gain_q8      (gain_q8_q),
		.trigger_step (trigger_step_q),
		.row          (f_row),
		.draw         (f_draw),
		.hit          (f_hit)
	);

	// Column the sample would record into, from the committed state
	assign unarmed  = single_mode_q && !armed_q;
	assign wrap_now = wcol_q >= CNT_W'(COLUMNS);
	assign rd_col   = (unarmed || wrap_now) ? '0 : wcol_q[IDX_W-1:0];

	// Record stage load and line store port
	always_ff @(posedge clk) begin
		if (move) begin
			row_s2  <= f_row;
			draw_s2 <= f_draw;
			hit_s2  <= f_hit;
			col_s2  <= rd_col;
			wrap_s2 <= wrap_now && !unarmed;
			idle_s2 <= unarmed;
			old_s2  <= line_mem[rd_col];
			oldv_s2 <= colv_q[rd_col];
		end
		if (commit && record)
			line_mem[col_s2] <= row_s2;
	end

	// Erase, stop and draw decisions
	always_comb begin
		record   = !idle_s2 || hit_s2;
		filled_n = filled_q || wrap_s2;
		old_row  = oldv_s2 ? old_s2 : '0;
		erase    = record && filled_n && (old_row > ROW_W'(ROW_TOP)) &&
		           (old_row != ROW_W'(ROW_MID)) && (old_row != ROW_W'(ROW_BOTTOM)) &&
		           !is_grid_col(COL_OUT_W'(col_s2));
		stop     = (col_s2 > IDX_W'(1)) && single_mode_q && (ls0_q < ls1_q);
		draw     = record && draw_s2;

		draw_op.column   = COL_OUT_W'(col_s2);
		draw_op.row      = row_s2;
		draw_op.pixel_on = 1'b1;
		draw_op.last     = 1'b1;

		erase_op.column   = COL_OUT_W'(col_s2);
		erase_op.row      = old_row;
		erase_op.pixel_on = 1'b0;
		erase_op.last     = !draw;

		push.first_en  = commit && (erase || draw);
		push.second_en = commit && erase && draw;
		push.first     = erase ? erase_op : draw_op;
		push.second    = draw_op;
	end

	// Trace state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcol_q   <= '0;
			filled_q <= 1'b0;
			armed_q  <= 1'b0;
			ls0_q    <= '0;
			ls1_q    <= '0;
			colv_q   <= '0;
		end else if (commit) begin
			if (record) begin
				wcol_q         <= CNT_W'(col_s2) + CNT_W'(1);
				filled_q       <= filled_n;
				armed_q        <= (idle_s2 || armed_q) && !wrap_s2 && !stop;
				colv_q[col_s2] <= 1'b1;
				if (col_s2 == IDX_W'(0))
					ls0_q <= row_s2;
				if (col_s2 == IDX_W'(1))
					ls1_q <= row_s2;
			end else begin
				wcol_q <= '0;
			end
		end
	end

	stcp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_valid && out_ready),
		.head      (head),
		.not_empty (out_valid),
		.room2     (room2)
	);

	assign column   = head.column;
	assign row      = head.row;
	assign pixel_on = head.pixel_on;
	assign last     = head.last;

endmodule

// ----- hdl/stcp_checker.sv -----
// Port-level checks on the pixel operation stream of the scope capture block,
// bound to the top level. Depends on stcp_pkg.
`timescale 1ns / 1ps

module stcp_checker
	import stcp_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [COL_OUT_W-1:0] column,
	input logic [ROW_W-1:0]     row,
	input logic                 pixel_on,
	input logic                 last
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column) && $stable(row) &&
		$stable(pixel_on) && $stable(last))
		else $error("result changed while stalled");

	// Columns stay on screen
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, column} < 8'(COLUMNS))
		else $error("column beyond screen width");

	// A drawn point lies below the top band, no lower than the origin row, and is last
	a_draw_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_on |-> row > ROW_W'(ROW_TOP) && row <= ROW_W'(64) && last)
		else $error("draw row out of range");

	// Grid and border pixels are never erased
	a_erase_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_on |-> row > ROW_W'(ROW_TOP) && row != ROW_W'(ROW_MID) &&
		row != ROW_W'(ROW_BOTTOM) && !is_grid_col(column))
		else $error("erase of a grid or border pixel");

	// An erase that is not last is followed at once by the draw of the same column
	a_erase_then_draw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !pixel_on && !last |=>
		out_valid && pixel_on && column == $past(column))
		else $error("erase not followed by its draw");

endmodule

bind scope_trigger_capture_plot stcp_checker u_stcp_checker (.*);
